// ===== rtl/core/leb_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the line editor.
`default_nettype none
package leb_pkg;

    localparam int LEB_DW        = 8;
    localparam int LEB_REQ_W     = 2;
    localparam int LEB_CFG_IDX_W = 2;
    localparam int LEB_DEPTH_DEF = 256;

    // request types
    localparam logic [LEB_REQ_W-1:0] REQ_KEY    = 2'd0;
    localparam logic [LEB_REQ_W-1:0] REQ_SETCUR = 2'd1;
    localparam logic [LEB_REQ_W-1:0] REQ_CLEAR  = 2'd2;
    localparam logic [LEB_REQ_W-1:0] REQ_READ   = 2'd3;

    // configuration register indexes
    localparam logic [LEB_CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [LEB_CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
    localparam logic [LEB_CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

    localparam logic [LEB_DW-1:0] COLS_RESET = 8'd80;

    // key codes
    localparam logic [LEB_DW-1:0] KEY_BACKSPACE = 8'h08;
    localparam logic [LEB_DW-1:0] KEY_END       = 8'h14;
    localparam logic [LEB_DW-1:0] KEY_HOME      = 8'h15;
    localparam logic [LEB_DW-1:0] KEY_LEFT      = 8'h16;
    localparam logic [LEB_DW-1:0] KEY_UP        = 8'h17;
    localparam logic [LEB_DW-1:0] KEY_RIGHT     = 8'h18;
    localparam logic [LEB_DW-1:0] KEY_DOWN      = 8'h19;
    localparam logic [LEB_DW-1:0] KEY_DELETE    = 8'h1e;
    localparam logic [LEB_DW-1:0] KEY_PRINT_LO  = 8'h20;
    localparam logic [LEB_DW-1:0] KEY_PRINT_END = 8'd128;

    typedef struct packed {
        logic capture;  // latch the accepted request
        logic exec;     // apply cursor/length update, set up shift or read
        logic shift;    // one shift read step
        logic final_wr; // write the inserted character
        logic out;      // load the result register
    } t_cmd;

    typedef struct packed {
        logic do_ins;      // decoded request inserts (valid in exec)
        logic shift_need;  // decoded request needs a store shift (valid in exec)
        logic ins_pending; // latched: current request is an insert
        logic last;        // shift pointer has reached its end
        logic out_free;    // result register can take a new result
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/core/leb_ifs.sv =====
// Request and response channel interfaces of the line editor.
`default_nettype none
interface leb_req_if import leb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LEB_REQ_W-1:0] req_type;
    logic [LEB_DW-1:0]    key_code;
    logic                 suppress;
    logic [LEB_DW-1:0]    cursor_value;
    logic [LEB_DW-1:0]    read_index;

    modport source (output valid, req_type, key_code, suppress, cursor_value, read_index,
                    input ready);
    modport sink   (input valid, req_type, key_code, suppress, cursor_value, read_index,
                    output ready);
endinterface

interface leb_rsp_if import leb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [LEB_DW-1:0] cursor_pos;
    logic [LEB_DW-1:0] line_length;
    logic [LEB_DW-1:0] read_data;

    modport source (output valid, cursor_pos, line_length, read_data, input ready);
    modport sink   (input valid, cursor_pos, line_length, read_data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/leb_ctrl.sv =====
// Sequencer for the line editor: accept, execute, shift, insert write, respond.
`default_nettype none
module leb_ctrl import leb_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_st,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_FINAL = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_st.shift_need)
                    n_state = S_SHIFT;
                else if (i_st.do_ins)
                    n_state = S_FINAL;
                else
                    n_state = S_DONE;
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                if (i_st.last)
                    n_state = S_DRAIN;
            end
            // last pending shift write lands here
            S_DRAIN: begin
                n_state = i_st.ins_pending ? S_FINAL : S_DONE;
            end
            S_FINAL: begin
                o_cmd.final_wr = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

endmodule
`default_nettype wire

// ===== rtl/core/leb_dp.sv =====
// Line editor datapath: request decode, cursor/length/config registers, line store, result.
`default_nettype none
module leb_dp import leb_pkg::*; #(
    parameter int BUF_DEPTH = LEB_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_st,
    input  wire logic [LEB_REQ_W-1:0]     i_req_type,
    input  wire logic [LEB_DW-1:0]        i_key_code,
    input  wire logic                     i_suppress,
    input  wire logic [LEB_DW-1:0]        i_cursor_value,
    input  wire logic [LEB_DW-1:0]        i_read_index,
    input  wire logic                     i_cfg_we,
    input  wire logic [LEB_CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LEB_DW-1:0]        i_cfg_data,
    input  wire logic                     i_out_ready,
    output logic                          o_out_valid,
    output logic [LEB_DW-1:0]             o_cursor_pos,
    output logic [LEB_DW-1:0]             o_line_length,
    output logic [LEB_DW-1:0]             o_read_data
);

    localparam int AW = $clog2(BUF_DEPTH);
    localparam logic [LEB_DW-1:0] LEN_CAP   = LEB_DW'(BUF_DEPTH - 2);
    localparam logic [LEB_DW-1:0] LIMIT_MAX = LEB_DW'(BUF_DEPTH - 1);

    // latched request
    logic [LEB_REQ_W-1:0] r_req;
    logic [LEB_DW-1:0]    r_code;
    logic                 r_sup;
    logic [LEB_DW-1:0]    r_cval;
    logic [LEB_DW-1:0]    r_ridx;

    // editor state and configuration
    logic [LEB_DW-1:0] r_cursor;
    logic [LEB_DW-1:0] r_len;
    logic              r_en;
    logic [LEB_DW-1:0] r_limit;
    logic [LEB_DW-1:0] r_cols;

    // shift engine
    logic          r_ins;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] r_end;
    logic [AW-1:0] r_ins_pos;
    logic          r_wpend;
    logic [AW-1:0] r_waddr;
    logic          r_rd_hit;

    // line store
    logic [LEB_DW-1:0] r_mem [BUF_DEPTH];
    logic [LEB_DW-1:0] r_q;

    // result register
    logic              r_ovalid;
    logic [LEB_DW-1:0] r_ocur;
    logic [LEB_DW-1:0] r_olen;
    logic [LEB_DW-1:0] r_odata;

    // decode
    logic              key_ok;
    logic              printable;
    logic              room;
    logic [LEB_DW:0]   down_sum;
    logic [LEB_DW-1:0] n_cursor;
    logic [LEB_DW-1:0] n_len;
    logic              do_ins;
    logic              do_rem;
    logic [LEB_DW-1:0] rem_pos;
    logic [LEB_DW:0]   rem_next;
    logic              rd_hit;
    logic              shift_need;
    logic [LEB_DW-1:0] len_m1;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LEB_DW-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;

    always_comb begin
        key_ok    = (r_req == REQ_KEY) && r_en && !r_sup;
        printable = r_code inside {[KEY_PRINT_LO : KEY_PRINT_END - 8'd1]};
        room      = (r_len < LEN_CAP) && (r_len < r_limit);
        down_sum  = {1'b0, r_cursor} + {1'b0, r_cols};
        len_m1    = r_len - 8'd1;
        n_cursor  = r_cursor;
        n_len     = r_len;
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        rem_pos   = r_cursor;
        rd_hit    = 1'b0;
        case (r_req)
            REQ_KEY: begin
                if (key_ok) begin
                    case (r_code)
                        KEY_LEFT:  if (r_cursor != '0) n_cursor = r_cursor - 8'd1;
                        KEY_RIGHT: if (r_cursor < r_len) n_cursor = r_cursor + 8'd1;
                        KEY_UP:    if (r_cursor > r_cols) n_cursor = r_cursor - r_cols;
                        KEY_DOWN: begin
                            if (down_sum < {1'b0, r_len})
                                n_cursor = down_sum[LEB_DW-1:0];
                            else
                                n_cursor = r_len;
                        end
                        KEY_BACKSPACE: begin
                            if (r_cursor != '0) begin
                                do_rem   = 1'b1;
                                rem_pos  = r_cursor - 8'd1;
                                n_cursor = r_cursor - 8'd1;
                                n_len    = len_m1;
                            end
                        end
                        KEY_DELETE: begin
                            if (r_cursor < r_len) begin
                                do_rem = 1'b1;
                                n_len  = len_m1;
                            end
                        end
                        KEY_END:  n_cursor = r_len;
                        KEY_HOME: n_cursor = '0;
                        default: begin
                            if (printable && room) begin
                                do_ins   = 1'b1;
                                n_len    = r_len + 8'd1;
                                n_cursor = r_cursor + 8'd1;
                            end
                        end
                    endcase
                end
            end
            REQ_SETCUR: n_cursor = (r_cval > r_len) ? r_len : r_cval;
            REQ_CLEAR: begin
                n_cursor = '0;
                n_len    = '0;
            end
            REQ_READ: rd_hit = (r_ridx < r_len);
            default: ;
        endcase
        rem_next = {1'b0, rem_pos} + 9'd1;
        if (do_ins)
            shift_need = (r_len > r_cursor);
        else if (do_rem)
            shift_need = (rem_next < {1'b0, r_len});
        else
            shift_need = 1'b0;
    end

    assign o_st.do_ins      = do_ins;
    assign o_st.shift_need  = shift_need;
    assign o_st.ins_pending = r_ins;
    assign o_st.last        = (r_ptr == r_end);
    assign o_st.out_free    = !r_ovalid || i_out_ready;

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_code <= i_key_code;
            r_sup  <= i_suppress;
            r_cval <= i_cursor_value;
            r_ridx <= i_read_index;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en    <= 1'b0;
            r_limit <= '0;
            r_cols  <= COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ENABLE: r_en <= i_cfg_data[0];
                CFG_LIMIT: begin
                    if ({1'b0, i_cfg_data} >= (LEB_DW+1)'(BUF_DEPTH))
                        r_limit <= LIMIT_MAX;
                    else
                        r_limit <= i_cfg_data;
                end
                CFG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // cursor and length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_len    <= '0;
        end else if (i_cmd.exec) begin
            r_cursor <= n_cursor;
            r_len    <= n_len;
        end
    end

    // shift set-up and stepping; insert walks down, remove walks up
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ins     <= do_ins;
            r_ins_pos <= r_cursor[AW-1:0];
            r_rd_hit  <= rd_hit;
            if (do_ins) begin
                r_ptr <= len_m1[AW-1:0];
                r_end <= r_cursor[AW-1:0];
            end else begin
                r_ptr <= rem_next[AW-1:0];
                r_end <= len_m1[AW-1:0];
            end
        end else if (i_cmd.shift) begin
            if (r_ins) begin
                r_ptr   <= r_ptr - AW'(1);
                r_waddr <= r_ptr + AW'(1);
            end else begin
                r_ptr   <= r_ptr + AW'(1);
                r_waddr <= r_ptr - AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_wpend <= 1'b0;
        else
            r_wpend <= i_cmd.shift;
    end

    // the byte read in one step is written back in the following cycle
    assign mem_we    = r_wpend || i_cmd.final_wr;
    assign mem_waddr = i_cmd.final_wr ? r_ins_pos : r_waddr;
    assign mem_wdata = i_cmd.final_wr ? r_code : r_q;
    assign mem_re    = (i_cmd.exec && rd_hit) || i_cmd.shift;
    assign mem_raddr = i_cmd.exec ? r_ridx[AW-1:0] : r_ptr;

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_re)
            r_q <= r_mem[mem_raddr];
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ovalid <= 1'b0;
        else if (i_cmd.out)
            r_ovalid <= 1'b1;
        else if (i_out_ready)
            r_ovalid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out) begin
            r_ocur  <= r_cursor;
            r_olen  <= r_len;
            r_odata <= r_rd_hit ? r_q : '0;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_cursor_pos  = r_ocur;
    assign o_line_length = r_olen;
    assign o_read_data   = r_odata;

endmodule
`default_nettype wire

// ===== rtl/core/line_edit_buffer.sv =====
// Line editor top level: request channel in, one response per request out, config port.
// Requests (i_req): key, set cursor, clear line, read byte. Each accepted request gives
// exactly one response (o_rsp) with cursor, length and read byte (zero unless a read
// request hits a position below the length).
// One request is in flight at a time; i_req.ready is high only while the block is idle.
// The next request can be taken in the cycle after the response is loaded. The line
// store has one read and one write port and moves one byte per cycle, so a shift moves
// at most BUF_DEPTH-3 bytes.
// The response waits in its output register while o_rsp is stalled; the next request
// is taken and worked on meanwhile, and its result waits until that register frees.
// Configuration (i_cfg_*): 0 editor enable, 1 length limit, 2 column count; write only
// while idle. Synchronous active-low reset clears cursor, length and configuration
// (column count to 80); the store is not cleared since bytes past the length read as 0.
`default_nettype none
module line_edit_buffer import leb_pkg::*; #(
    parameter int BUF_DEPTH = LEB_DEPTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    leb_req_if.sink                       i_req,
    leb_rsp_if.source                     o_rsp,
    input  wire logic                     i_cfg_we,
    input  wire logic [LEB_CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [LEB_DW-1:0]        i_cfg_data
);

    t_cmd    cmd;
    t_status st;
    logic    in_ready;

    assign i_req.ready = in_ready;

    leb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    leb_dp #(
        .BUF_DEPTH (BUF_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_req_type     (i_req.req_type),
        .i_key_code     (i_req.key_code),
        .i_suppress     (i_req.suppress),
        .i_cursor_value (i_req.cursor_value),
        .i_read_index   (i_req.read_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_cursor_pos   (o_rsp.cursor_pos),
        .o_line_length  (o_rsp.line_length),
        .o_read_data    (o_rsp.read_data)
    );

endmodule
`default_nettype wire

// ===== bench/tb_line_edit_buffer.sv =====
// Self-checking bench for the line editor: directed script, random edit phases, shadow line model.
`default_nettype none
module tb_line_edit_buffer import leb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = LEB_DEPTH_DEF;
    localparam int PERIOD      = 10;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 20;
    localparam int NUM_PHASES  = 7;

    typedef struct packed {
        logic [LEB_REQ_W-1:0] kind;
        logic [LEB_DW-1:0]    key;
        logic                 sup;
        logic [LEB_DW-1:0]    cval;
        logic [LEB_DW-1:0]    ridx;
    } t_edit_req;

    typedef struct packed {
        logic [LEB_DW-1:0] cur;
        logic [LEB_DW-1:0] len;
        logic [LEB_DW-1:0] data;
    } t_line_view;

    typedef struct packed {
        logic                     is_cfg;
        logic [LEB_CFG_IDX_W-1:0] idx;
        logic [LEB_DW-1:0]        val;
        t_edit_req                rq;
        logic                     typed;
        t_line_view               want;
    } t_script_row;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [LEB_CFG_IDX_W-1:0] cfg_idx;
    logic [LEB_DW-1:0]        cfg_data;

    leb_req_if req_if();
    leb_rsp_if rsp_if();

    line_edit_buffer #(.BUF_DEPTH(DEPTH)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    // shadow copy of the editor
    logic [LEB_DW-1:0] shadow_line [DEPTH];
    int shadow_cur    = 0;
    int shadow_len    = 0;
    int shadow_en     = 0;
    int shadow_limit  = 0;
    int shadow_cols   = int'(COLS_RESET);

    t_line_view  views_due [$];
    t_script_row script [$];
    int  err_count = 0;
    int  rsp_seen  = 0;
    int  cycle_no  = 0;
    bit  idle_on   = 1'b1;

    int ph_en    [NUM_PHASES] = '{1, 1, 0, 1, 1, 1, 1};
    int ph_limit [NUM_PHASES] = '{255, 12, 255, 0, 254, 255, 40};
    int ph_cols  [NUM_PHASES] = '{80, 3, 1, 0, 255, 1, 0};
    int ph_items [NUM_PHASES] = '{350, 250, 80, 120, 300, 350, 250};

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic void drop_char(int pos);
        for (int i = pos; i + 1 < shadow_len; i++)
            shadow_line[i] = shadow_line[i + 1];
        shadow_len--;
        shadow_line[shadow_len] = '0;
    endfunction

    function automatic t_line_view apply_edit(t_edit_req r);
        t_line_view v;
        v.data = '0;
        case (r.kind)
            REQ_KEY: begin
                if (shadow_en != 0 && !r.sup) begin
                    case (r.key)
                        KEY_LEFT:  if (shadow_cur > 0) shadow_cur--;
                        KEY_RIGHT: if (shadow_cur < shadow_len) shadow_cur++;
                        KEY_UP:    if (shadow_cur > shadow_cols) shadow_cur -= shadow_cols;
                        KEY_DOWN: begin
                            if (shadow_cur + shadow_cols < shadow_len)
                                shadow_cur += shadow_cols;
                            else
                                shadow_cur = shadow_len;
                        end
                        KEY_BACKSPACE: begin
                            if (shadow_cur > 0) begin
                                drop_char(shadow_cur - 1);
                                shadow_cur--;
                            end
                        end
                        KEY_DELETE: if (shadow_cur < shadow_len) drop_char(shadow_cur);
                        KEY_END:    shadow_cur = shadow_len;
                        KEY_HOME:   shadow_cur = 0;
                        default: begin
                            if ((r.key inside {[KEY_PRINT_LO : KEY_PRINT_END - 8'd1]}) &&
                                shadow_len < DEPTH - 2 && shadow_len < shadow_limit) begin
                                for (int i = shadow_len; i > shadow_cur; i--)
                                    shadow_line[i] = shadow_line[i - 1];
                                shadow_line[shadow_cur] = r.key;
                                shadow_len++;
                                shadow_cur++;
                            end
                        end
                    endcase
                end
            end
            REQ_SETCUR: shadow_cur = (int'(r.cval) > shadow_len) ? shadow_len : int'(r.cval);
            REQ_CLEAR: begin
                shadow_len     = 0;
                shadow_cur     = 0;
                shadow_line[0] = '0;
            end
            default: begin
                if (int'(r.ridx) < shadow_len)
                    v.data = shadow_line[r.ridx];
            end
        endcase
        v.cur = shadow_cur[LEB_DW-1:0];
        v.len = shadow_len[LEB_DW-1:0];
        return v;
    endfunction

    function automatic t_edit_req pick_edit();
        t_edit_req r;
        int roll;
        r.key  = 8'($urandom_range(0, 255));
        r.sup  = ($urandom_range(0, 15) == 0);
        r.cval = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, shadow_len + 1));
        r.ridx = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, shadow_len));
        roll = $urandom_range(0, 99);
        if (roll < 70)      r.kind = REQ_KEY;
        else if (roll < 80) r.kind = REQ_SETCUR;
        else if (roll < 82) r.kind = REQ_CLEAR;
        else                r.kind = REQ_READ;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            r.key = 8'($urandom_range(int'(KEY_PRINT_LO), int'(KEY_PRINT_END) - 1));
        end else if (roll < 90) begin
            case ($urandom_range(0, 7))
                0: r.key = KEY_LEFT;
                1: r.key = KEY_RIGHT;
                2: r.key = KEY_UP;
                3: r.key = KEY_DOWN;
                4: r.key = KEY_BACKSPACE;
                5: r.key = KEY_DELETE;
                6: r.key = KEY_END;
                default: r.key = KEY_HOME;
            endcase
        end
        return r;
    endfunction

    function automatic void add_req(logic [LEB_REQ_W-1:0] kind, logic [LEB_DW-1:0] key,
                                    logic sup, logic [LEB_DW-1:0] cval,
                                    logic [LEB_DW-1:0] ridx, logic typed = 1'b0,
                                    t_line_view want = '0);
        t_script_row row;
        row        = '0;
        row.rq     = {kind, key, sup, cval, ridx};
        row.typed  = typed;
        row.want   = want;
        script.insert(script.size(), row);
    endfunction

    function automatic void add_cfg(logic [LEB_CFG_IDX_W-1:0] idx, logic [LEB_DW-1:0] val);
        t_script_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        script.insert(script.size(), row);
    endfunction

    task automatic send_edit(t_edit_req r);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            @(negedge clk) req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid        <= 1'b1;
        req_if.req_type     <= r.kind;
        req_if.key_code     <= r.key;
        req_if.suppress     <= r.sup;
        req_if.cursor_value <= r.cval;
        req_if.read_index   <= r.ridx;
        do @(posedge clk); while (!req_if.ready);
    endtask

    task automatic run_edit(t_edit_req r, logic typed, t_line_view want);
        t_line_view v;
        send_edit(r);
        v = apply_edit(r);
        views_due.insert(views_due.size(), typed ? want : v);
    endtask

    task automatic wait_drained();
        @(negedge clk) req_if.valid <= 1'b0;
        while (views_due.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [LEB_CFG_IDX_W-1:0] idx, logic [LEB_DW-1:0] val);
        wait_drained();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk) cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE: shadow_en    = int'(val[0]);
            CFG_LIMIT:  shadow_limit = (int'(val) >= DEPTH) ? DEPTH - 1 : int'(val);
            CFG_COLS:   shadow_cols  = int'(val);
            default: ;
        endcase
    endtask

    // response side: random stalls, plus two long hold-offs to back the block up
    initial begin : rsp_sink
        int stall;
        int next_hold;
        next_hold    = 600;
        rsp_if.ready = 1'b0;
        forever begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (rsp_seen >= next_hold) begin
                stall     = HOLD_CYCLES;
                next_hold = next_hold + 900;
            end
            if (stall > 0) begin
                @(negedge clk) rsp_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk) rsp_if.ready <= 1'b1;
            do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
        end
    end

    always @(posedge clk) begin : rsp_check
        t_line_view want;
        if (rst_n && rsp_if.valid && rsp_if.ready) begin
            rsp_seen++;
            if (views_due.size() == 0) begin
                report_mismatch($sformatf("response with nothing pending (cur %0d len %0d)",
                                          rsp_if.cursor_pos, rsp_if.line_length));
            end else begin
                want = views_due.pop_front();
                if (rsp_if.cursor_pos !== want.cur)
                    report_mismatch($sformatf("cursor_pos got %0d want %0d",
                                              rsp_if.cursor_pos, want.cur));
                if (rsp_if.line_length !== want.len)
                    report_mismatch($sformatf("line_length got %0d want %0d",
                                              rsp_if.line_length, want.len));
                if (rsp_if.read_data !== want.data)
                    report_mismatch($sformatf("read_data got %0h want %0h",
                                              rsp_if.read_data, want.data));
            end
        end
    end

    always @(posedge clk) begin
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        t_edit_req r;
        int counted;
        int fill;

        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = '0;
        cfg_data            = '0;
        req_if.valid        = 1'b0;
        req_if.req_type     = REQ_READ;
        req_if.key_code     = '0;
        req_if.suppress     = 1'b0;
        req_if.cursor_value = '0;
        req_if.read_index   = '0;
        foreach (shadow_line[i]) shadow_line[i] = '0;

        // after reset: editor off, limit 0
        add_req(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd0,   1'b1, {8'd0, 8'd0, 8'd0});
        add_req(REQ_KEY,    8'h41, 1'b0, 8'd0,   8'd0,   1'b1, {8'd0, 8'd0, 8'd0});
        add_req(REQ_SETCUR, 8'h00, 1'b0, 8'd255, 8'd0,   1'b1, {8'd0, 8'd0, 8'd0});
        add_req(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd255, 1'b1, {8'd0, 8'd0, 8'd0});
        add_cfg(CFG_ENABLE, 8'd1);
        add_req(REQ_KEY,    8'h42, 1'b0, 8'd0,   8'd0,   1'b1, {8'd0, 8'd0, 8'd0});
        add_cfg(CFG_LIMIT, 8'd255);
        add_cfg(CFG_COLS, 8'd2);
        // printable extremes, then unknown codes and a suppressed key
        add_req(REQ_KEY,    8'h20, 1'b0, 8'd0,   8'd0,   1'b1, {8'd1, 8'd1, 8'd0});
        add_req(REQ_KEY,    8'h7f, 1'b0, 8'd0,   8'd0,   1'b1, {8'd2, 8'd2, 8'd0});
        add_req(REQ_KEY,    8'h80, 1'b0, 8'd0,   8'd0,   1'b1, {8'd2, 8'd2, 8'd0});
        add_req(REQ_KEY,    8'hff, 1'b0, 8'd0,   8'd0,   1'b1, {8'd2, 8'd2, 8'd0});
        add_req(REQ_KEY,    8'h78, 1'b1, 8'd0,   8'd0,   1'b1, {8'd2, 8'd2, 8'd0});
        add_req(REQ_READ,   8'h00, 1'b0, 8'd0,   8'd1,   1'b1, {8'd2, 8'd2, 8'h7f});
        add_req(REQ_KEY,    KEY_LEFT,      1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    8'h4d,         1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_HOME,      1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_LEFT,      1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_BACKSPACE, 1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_END,       1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_RIGHT,     1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_DELETE,    1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_UP,        1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_DOWN,      1'b0, 8'd0, 8'd0);
        add_req(REQ_KEY,    KEY_BACKSPACE, 1'b0, 8'd0, 8'd0);
        add_req(REQ_SETCUR, 8'h00,         1'b0, 8'd1, 8'd0);
        add_req(REQ_KEY,    KEY_DELETE,    1'b0, 8'd0, 8'd0);
        add_req(REQ_READ,   8'h00,         1'b0, 8'd0, 8'd255);
        add_req(REQ_CLEAR,  8'h00,         1'b0, 8'd0, 8'd0);

        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        foreach (script[n]) begin
            if (script[n].is_cfg)
                write_reg(script[n].idx, script[n].val);
            else
                run_edit(script[n].rq, script[n].typed, script[n].want);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_ENABLE, 8'(ph_en[ph]));
            write_reg(CFG_LIMIT, 8'(ph_limit[ph]));
            write_reg(CFG_COLS, 8'(ph_cols[ph]));
            idle_on = (ph % 3) != 1;
            counted = 0;
            while (counted < ph_items[ph]) begin
                // now and then a run of typing, to push the line towards full
                fill = ($urandom_range(0, 39) == 0) ? $urandom_range(20, 60) : 0;
                do begin
                    r = pick_edit();
                    if (fill > 0) begin
                        r.kind = REQ_KEY;
                        r.sup  = 1'b0;
                        r.key  = 8'($urandom_range(int'(KEY_PRINT_LO),
                                                   int'(KEY_PRINT_END) - 1));
                        fill--;
                    end
                    counted++;
                    run_edit(r, 1'b0, '0);
                end while (fill > 0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
